### src/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants
// Operation codes, status codes and the transfer payload types of the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [2:0] OP_MAKE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_CMP  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam int MAG_BITS  = 33;
  localparam int WIDE_BITS = 66;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic [1:0]         status;
  } out_item_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic [2:0]          op;
    logic                zero_den;
    logic                a_neg;
    logic                b_neg;
    logic [MAG_BITS-1:0] na;
    logic [MAG_BITS-1:0] da;
    logic [MAG_BITS-1:0] nb;
    logic [MAG_BITS-1:0] db;
  } job_t;

endpackage

### src/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction arithmetic with gcd reduction
// Make, add, subtract, multiply, divide and compare on pairs of fractions.
// ----------------------------------------------------------------------------
// An item passes through the cross multiplies, a binary gcd loop, then two
// bit-serial divisions by the gcd. Zero-denominator items go straight to
// the output register, and compares skip the gcd and the divisions. A
// two-entry queue lets the front take new items while the back works.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output rau_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);

  rau_pkg::job_t f_job, q_job;
  logic          f_valid, f_ready, q_valid, q_ready;

  rau_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk, .rst, .in_item(in_data), .in_valid, .in_ready,
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  rau_queue u_queue (
    .clk, .rst, .wr_job(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_job(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  rau_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk, .rst, .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
    .out_item(out_data), .out_valid, .out_ready
  );

endmodule

### src/rau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front: operand intake
// Accepts items, decodes opcodes, takes magnitudes and signs and flags zero
// denominators, then passes a job to the queue.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::in_item_t in_item,
  input  logic              in_valid,
  output logic              in_ready,
  output rau_pkg::job_t     job,
  output logic              job_valid,
  input  logic              job_ready
);

  localparam int MB = rau_pkg::MAG_BITS;

  rau_pkg::job_t job_next;

  function automatic logic [MB:0] take(input logic [31:0] raw);
    logic [WORD_BITS-1:0] v;
    logic [MB-1:0]        m;
    v = raw[WORD_BITS-1:0];
    if (v[WORD_BITS-1]) begin
      m = MB'(({1'b0, {WORD_BITS{1'b0}}} - {1'b0, v}) & {1'b0, {WORD_BITS{1'b1}}});
      if (m == '0) m = MB'({1'b1, {WORD_BITS{1'b0}}});
      return {1'b1, m};
    end
    return {1'b0, MB'(v)};
  endfunction

  always_comb begin
    logic [MB:0] an, ad, bn, bd;
    logic [2:0]  op;
    op = in_item.opcode;
    if (op > rau_pkg::OP_CMP) op = rau_pkg::OP_MAKE;
    an = take(in_item.a_num);
    ad = take(in_item.a_den);
    bn = take(in_item.b_num);
    bd = take(in_item.b_den);
    job_next.op = op;
    job_next.zero_den = (ad[MB-1:0] == '0) ||
                        (op != rau_pkg::OP_MAKE && bd[MB-1:0] == '0) ||
                        (op == rau_pkg::OP_DIV && bn[MB-1:0] == '0);
    job_next.na = an[MB-1:0];
    job_next.da = ad[MB-1:0];
    job_next.nb = bn[MB-1:0];
    job_next.db = bd[MB-1:0];
    job_next.a_neg = (an[MB] != ad[MB]) && an[MB-1:0] != '0;
    job_next.b_neg = (bn[MB] != bd[MB]) && bn[MB-1:0] != '0;
  end

  assign in_ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid;
    end
    if (in_valid && in_ready) job <= job_next;
  end

endmodule

### src/rau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_queue: job queue
// A two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rau_queue (
  input  logic          clk,
  input  logic          rst,
  input  rau_pkg::job_t wr_job,
  input  logic          wr_valid,
  output logic          wr_ready,
  output rau_pkg::job_t rd_job,
  output logic          rd_valid,
  input  logic          rd_ready
);

  rau_pkg::job_t mem [2];
  logic          wp, rp;
  logic [1:0]    count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_job   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
    if (wr_valid && wr_ready) mem[wp] <= wr_job;
  end

endmodule

### src/rau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back: arithmetic engine
// Forms cross products, adds, reduces by a binary gcd and two restoring
// divisions, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module rau_back #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_ready,
  output rau_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int W  = rau_pkg::WIDE_BITS;
  localparam logic [W-1:0] HALF = W'(1) << (WORD_BITS - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL1 = 9'b000000010,
    S_MUL2 = 9'b000000100,
    S_SUM  = 9'b000001000,
    S_GCD  = 9'b000010000,
    S_DIVN = 9'b000100000,
    S_DIVD = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t             state;
  rau_pkg::job_t      j;
  rau_pkg::out_item_t res;
  logic [W-1:0]       p1, p2, pd, rn, rd, ga, gb, g, quo, rem;
  logic [6:0]         shift, bit_cnt;
  logic               rneg, l_neg, r_neg;
  logic [W:0]         trial;

  assign job_ready = state == S_IDLE;
  assign trial = {rem[W-1:0], quo[W-1]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            j     <= job;
            state <= job.zero_den ? S_OUT : S_MUL1;
            res   <= rau_pkg::out_item_t'({66'd0,
                       job.zero_den ? rau_pkg::ST_ZERO_DEN : rau_pkg::ST_OK});
          end
        end
        S_MUL1: begin
          p1 <= W'(j.na) * W'(j.db);
          p2 <= W'(j.nb) * W'(j.da);
          state <= S_MUL2;
        end
        S_MUL2: begin
          unique case (j.op)
            rau_pkg::OP_MUL: begin
              p1 <= W'(j.na) * W'(j.nb);
              pd <= W'(j.da) * W'(j.db);
            end
            rau_pkg::OP_DIV: pd <= W'(j.da) * W'(j.nb);
            default:         pd <= W'(j.da) * W'(j.db);
          endcase
          l_neg <= j.a_neg;
          r_neg <= (j.op == rau_pkg::OP_SUB) ? !j.b_neg : j.b_neg;
          state <= S_SUM;
        end
        S_SUM: begin
          logic         rz;
          logic [W-1:0] sn;
          logic         sg;
          rz = p2 == '0;
          if (!rz && l_neg == r_neg)  begin sn = p1 + p2; sg = l_neg; end
          else if (rz || p1 >= p2)    begin sn = p1 - p2; sg = l_neg; end
          else                        begin sn = p2 - p1; sg = r_neg; end
          if (sn == '0) sg = 1'b0;
          if (j.op == rau_pkg::OP_CMP) begin
            logic lneg, rneg2, lt, eq, gt;
            lneg  = l_neg && p1 != '0;
            rneg2 = j.b_neg && p2 != '0;
            lt = 1'b0;
            eq = 1'b0;
            gt = 1'b0;
            if (lneg != rneg2) begin
              lt = lneg;
              gt = !lneg;
            end else if (p1 == p2) begin
              eq = 1'b1;
            end else begin
              lt = (p1 < p2) != lneg;
              gt = (p1 < p2) == lneg;
            end
            res   <= rau_pkg::out_item_t'({63'd0, lt, eq, gt, rau_pkg::ST_OK});
            state <= S_OUT;
          end else begin
            unique case (j.op)
              rau_pkg::OP_MAKE: begin rn <= W'(j.na); rd <= W'(j.da); rneg <= j.a_neg;
                ga <= W'(j.na); gb <= W'(j.da); end
              rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin rn <= sn; rd <= pd; rneg <= sg;
                ga <= sn; gb <= pd; end
              default: begin rn <= p1; rd <= pd; rneg <= j.a_neg != j.b_neg;
                ga <= p1; gb <= pd; end
            endcase
            shift <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (ga == '0) begin
            g <= gb << shift;
            state <= S_DIVN;
            quo <= rn; rem <= '0; bit_cnt <= '0;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1; gb <= gb >> 1; shift <= shift + 7'd1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= (ga - gb) >> 1;
          end else begin
            gb <= (gb - ga) >> 1;
          end
        end
        S_DIVN, S_DIVD: begin
          logic [W-1:0] quo_step, rem_step;
          quo_step = {quo[W-2:0], !trial[W]};
          rem_step = trial[W] ? {rem[W-2:0], quo[W-1]} : trial[W-1:0];
          if (bit_cnt == 7'(W - 1)) begin
            bit_cnt <= '0;
            rem <= '0;
            if (state == S_DIVN) begin
              rn    <= quo_step;
              quo   <= rd;
              state <= S_DIVD;
            end else begin
              rd    <= quo_step;
              state <= S_FIN;
            end
          end else begin
            bit_cnt <= bit_cnt + 7'd1;
            rem     <= rem_step;
            quo     <= quo_step;
          end
        end
        S_FIN: begin
          logic        neg;
          logic [31:0] nv;
          neg = rneg && rn != '0;
          nv = neg ? 32'(W'(0) - rn) : 32'(rn);
          if ((neg ? (rn > HALF) : (rn > HALF - W'(1))) || rd > HALF - W'(1)) begin
            res <= rau_pkg::out_item_t'({66'd0, rau_pkg::ST_OVERFLOW});
          end else begin
            res <= rau_pkg::out_item_t'({nv, 31'(rd), 3'b000, rau_pkg::ST_OK});
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
    end
  end

endmodule

### src/rau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker: port-level checks
// Checks on result transfers seen at the top-level ports.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic               clk,
  input logic               rst,
  input rau_pkg::out_item_t out_data,
  input logic               out_valid,
  input logic               out_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({out_data.is_less, out_data.is_equal, out_data.is_greater}))
    else $error("more than one compare flag");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != rau_pkg::ST_OK |-> out_data.res_den == '0)
    else $error("error result carries a denominator");

  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.res_den == '0 |-> out_data.res_num == '0)
    else $error("numerator without denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_checker (
  .clk, .rst, .out_data, .out_valid, .out_ready
);

### bench/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction unit
// A queue of operations feeds a valid/ready driver. A monitor compares
// every result transfer with the value computed by an independent
// fraction calculator, under random idling on both sides and a long hold of out_ready.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  rau_pkg::in_item_t  in_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_taken = 1'b0;
  rau_pkg::out_item_t out_data;
  logic               out_valid;
  logic               out_ready = 1'b0;

  rau_pkg::in_item_t  pending_ops[$];
  rau_pkg::out_item_t expected_results[$];
  int                 errors = 0;
  int                 checked = 0;
  int                 cycles = 0;
  int                 send_idle_pct = 36;
  int                 recv_idle_pct = 81;
  int                 phase_num = 0;
  int                 hold_off = 0;
  bit                 held = 1'b0;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 3000;

  rational_arithmetic_unit #(.WORD_BITS(32)) i_dut (
    .clk(clk), .rst(rst),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  always #1 clk = ~clk;

  function automatic logic [127:0] gcd_of(logic [127:0] x, logic [127:0] y);
    logic [127:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic rau_pkg::out_item_t reduce_fraction(rau_pkg::in_item_t it);
    rau_pkg::out_item_t r;
    logic [2:0]         op;
    logic [127:0]       na, da, nb, db, rn, rd, l, rr, g;
    logic               an_s, ad_s, bn_s, bd_s, a_neg, b_neg, rneg, ln, rgn;
    logic [127:0]       half;
    half = 128'd1 << 31;
    r = '0;
    op = (it.opcode > rau_pkg::OP_CMP) ? rau_pkg::OP_MAKE : it.opcode;
    an_s = it.a_num[31]; ad_s = it.a_den[31];
    bn_s = it.b_num[31]; bd_s = it.b_den[31];
    na = an_s ? ((128'd1 << 32) - 128'({1'b0, it.a_num})) : 128'({1'b0, it.a_num});
    da = ad_s ? ((128'd1 << 32) - 128'({1'b0, it.a_den})) : 128'({1'b0, it.a_den});
    nb = bn_s ? ((128'd1 << 32) - 128'({1'b0, it.b_num})) : 128'({1'b0, it.b_num});
    db = bd_s ? ((128'd1 << 32) - 128'({1'b0, it.b_den})) : 128'({1'b0, it.b_den});
    if (da == 0 || (op != rau_pkg::OP_MAKE && db == 0) ||
        (op == rau_pkg::OP_DIV && nb == 0)) begin
      r.status = rau_pkg::ST_ZERO_DEN;
      return r;
    end
    a_neg = (an_s != ad_s) && na != 0;
    b_neg = (bn_s != bd_s) && nb != 0;
    if (op == rau_pkg::OP_CMP) begin
      l = na * db;
      rr = nb * da;
      ln = a_neg && l != 0;
      rgn = b_neg && rr != 0;
      if (ln != rgn) begin
        r.is_less = ln;
        r.is_greater = !ln;
      end else if (l == rr) r.is_equal = 1'b1;
      else if (!ln) begin
        r.is_less = l < rr;
        r.is_greater = l > rr;
      end else begin
        r.is_less = l > rr;
        r.is_greater = l < rr;
      end
      return r;
    end
    case (op)
      rau_pkg::OP_MAKE: begin
        rneg = a_neg; rn = na; rd = da;
      end
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        l = na * db;
        rr = nb * da;
        ln = a_neg;
        rgn = (op == rau_pkg::OP_SUB) ? !b_neg : b_neg;
        if (rr == 0) rgn = 1'b0;
        if (ln == rgn) begin
          rneg = ln; rn = l + rr;
        end else if (l >= rr) begin
          rneg = ln; rn = l - rr;
        end else begin
          rneg = rgn; rn = rr - l;
        end
        rd = da * db;
      end
      rau_pkg::OP_MUL: begin
        rneg = a_neg != b_neg; rn = na * nb; rd = da * db;
      end
      default: begin
        rneg = a_neg != b_neg; rn = na * db; rd = da * nb;
      end
    endcase
    g = gcd_of(rn, rd);
    rn = rn / g;
    rd = rd / g;
    if (rn == 0) rneg = 1'b0;
    if ((rneg ? (rn > half) : (rn > half - 1)) || rd > half - 1) begin
      r.status = rau_pkg::ST_OVERFLOW;
      return r;
    end
    r.res_num = rneg ? -rn[31:0] : rn[31:0];
    r.res_den = rd[30:0];
    r.status = rau_pkg::ST_OK;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 20)) - 10);
      3: return 32'($urandom_range(0, 1000));
      4: return -32'($urandom_range(1, 1000));
      5: return 32'($urandom_range(0, 65535)) * 32'($urandom_range(1, 6));
      default: return $urandom;
    endcase
  endfunction

  function automatic rau_pkg::in_item_t make_op(logic [2:0] op, logic [31:0] an,
                                                logic [31:0] ad, logic [31:0] bn,
                                                logic [31:0] bd);
    rau_pkg::in_item_t it;
    it.opcode = op; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
    return it;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        expected_results.push_back(reduce_fraction(in_data));
        void'(pending_ops.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_ops[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (phase_num == 2 && !held) begin
        held <= 1'b1;
        hold_off <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors <= errors + 1;
      end else begin
        if (out_data !== expected_results[0]) begin
          $display("%0t: mismatch expected %h actual %h", $time, expected_results[0],
                   out_data);
          errors <= errors + 1;
        end
        checked <= checked + 1;
        void'(expected_results.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] xs[6];
    int k;
    xs = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd6};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int op = 0; op < 8; op++)
      pending_ops.push_back(make_op(op[2:0], 32'd6, -32'd4, 32'd3, 32'd9));
    pending_ops.push_back(make_op(rau_pkg::OP_MAKE, 32'd5, 32'd0, 32'd1, 32'd1));
    pending_ops.push_back(make_op(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0));
    pending_ops.push_back(make_op(rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd0, 32'd7));
    pending_ops.push_back(make_op(rau_pkg::OP_MAKE, 32'h8000_0000, 32'hffff_ffff,
                                  32'd0, 32'd0));
    pending_ops.push_back(make_op(rau_pkg::OP_MAKE, 32'd0, -32'd7, 32'd0, 32'd0));
    pending_ops.push_back(make_op(rau_pkg::OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff,
                                  32'd1));
    pending_ops.push_back(make_op(rau_pkg::OP_DIV, 32'd1, 32'h8000_0000, 32'd1, 32'd1));
    pending_ops.push_back(make_op(rau_pkg::OP_SUB, 32'h8000_0000, 32'd1, 32'h8000_0000,
                                  32'd1));
    pending_ops.push_back(make_op(rau_pkg::OP_CMP, 32'd1, 32'd2, -32'd2, -32'd4));
    pending_ops.push_back(make_op(rau_pkg::OP_CMP, 32'd0, 32'd3, 32'd0, -32'd5));
    pending_ops.push_back(make_op(rau_pkg::OP_CMP, -32'd1, 32'd3, 32'd1, 32'd3));
    pending_ops.push_back(make_op(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'd1,
                                  32'h7fff_ffff));
    for (k = 0; k < 6; k++)
      pending_ops.push_back(make_op(rau_pkg::OP_CMP, xs[k], xs[(k + 1) % 6],
                                    xs[(k + 3) % 6], xs[(k + 4) % 6]));
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 36 : 0;
      phase_num = phase;
      for (k = 0; k < 300; k++)
        pending_ops.push_back(make_op(3'($urandom_range(0, 7)), pick_word(), pick_word(),
                                      pick_word(), pick_word()));
      wait_drained();
    end
    repeat (300) @(posedge clk);
    $display("checked %0d results across all six operations, error cases and stalls",
             checked);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### rational_arithmetic_unit.f
src/rau_pkg.sv
src/rau_front.sv
src/rau_queue.sv
src/rau_back.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
bench/rational_arithmetic_unit_tb.sv
